// ----- hw/rtl/bcgrb_pkg.sv -----
package bcgrb_pkg;

   localparam int PortPinsDefault = 16;

   localparam int DataWidth   = 32;
   localparam int HalfWidth   = 16;
   localparam int OffsetWidth = 6;
   localparam int CableWidth  = 2;

   // register reset values
   localparam logic [HalfWidth-1:0] BusCtrl2Reset  = 16'h3FFC;
   localparam logic [DataWidth-1:0] WaitCtrl1Reset = 32'h7777_7777;
   localparam logic [DataWidth-1:0] WaitCtrl2Reset = 32'hFFFE_EFFF;
   localparam logic [DataWidth-1:0] WaitCtrl3Reset = 32'h0777_7777;

   // cable sense decode of port A control/data low nibbles
   localparam logic [3:0] SenseCtrlOut   = 4'h8;
   localparam logic [3:0] SenseCtrlMixed = 4'hB;
   localparam logic [3:0] SenseCtrlIn    = 4'hC;
   localparam logic [3:0] SenseDataLow   = 4'h2;
   localparam logic [1:0] SenseAll       = 2'b11;

   typedef enum logic [0:0] {
      MODE_READ  = 1'b0,
      MODE_WRITE = 1'b1
   } mode_type;

   typedef enum logic [OffsetWidth-1:0] {
      OFF_BUS_CTRL1   = 6'd0,
      OFF_BUS_CTRL2   = 6'd1,
      OFF_WAIT_CTRL1  = 6'd2,
      OFF_WAIT_CTRL2  = 6'd3,
      OFF_WAIT_CTRL3  = 6'd4,
      OFF_MEM_CTRL    = 6'd5,
      OFF_CARD_CTRL   = 6'd6,
      OFF_REFRESH0    = 6'd7,
      OFF_REFRESH1    = 6'd8,
      OFF_REFRESH2    = 6'd9,
      OFF_REFRESH3    = 6'd10,
      OFF_PORT_A_CTRL = 6'd11,
      OFF_PORT_A_DATA = 6'd12,
      OFF_PORT_B_CTRL = 6'd16,
      OFF_PORT_B_DATA = 6'd17,
      OFF_GPIO_IRQ    = 6'd18
   } reg_offset_type;

   localparam logic [1:0] RefreshBase = 2'd3; // low bits of the first refresh offset

endpackage

// ----- hw/rtl/bus_controller_gpio_register_block.sv -----
// Bus controller register file with GPIO port A pin control.
//
// Request channel: drive start high with req_mode (0 read, 1 write),
// req_reg_offset (word index) and req_write_data. A beat is taken at any
// rising edge where start is high and busy is low; busy is high only while
// reset is asserted, so one access can be taken every cycle.
// Response channel: rsp_valid is high for exactly one cycle per access, once the
// access has passed the request register, then decode and the result register,
// and the receiver takes that beat while rsp_valid is high. The
// response carries read data, the access error flag and the port A pin state
// as it stands after the access. Throughput is one access per cycle outside reset; the
// figure is set by the single decode stage between the request register and
// the state/result registers. The receiver has no way to stall a response.
// Configuration: csr_write_enable loads csr_write_data into the cable type
// field reported on port A data reads; write it only while no access is in
// flight.
// Reset (synchronous, active high) loads every register-file register with its
// documented value, clears port A data, the pin masks and the latch, and drops
// any access still in the pipe.
module bus_controller_gpio_register_block #(
   parameter int PORT_PINS = bcgrb_pkg::PortPinsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic [bcgrb_pkg::OffsetWidth-1:0]     req_reg_offset,
   input  logic [bcgrb_pkg::DataWidth-1:0]       req_write_data,
   output logic                                  rsp_valid,
   output logic [bcgrb_pkg::DataWidth-1:0]       rsp_read_data,
   output logic                                  rsp_access_error,
   output logic [bcgrb_pkg::HalfWidth-1:0]       rsp_port_a_drive,
   output logic [bcgrb_pkg::HalfWidth-1:0]       rsp_port_a_output_mask,
   output logic [bcgrb_pkg::HalfWidth-1:0]       rsp_port_a_pullup_mask,
   input  logic                                  csr_write_enable,
   input  logic [bcgrb_pkg::CableWidth-1:0]      csr_write_data
);

   localparam int DW = bcgrb_pkg::DataWidth;
   localparam int HW = bcgrb_pkg::HalfWidth;

   // request register
   logic                               req_valid_ff;
   bcgrb_pkg::mode_type                req_mode_ff;
   bcgrb_pkg::reg_offset_type          req_offset_ff;
   logic [DW-1:0]                      req_wdata_ff;

   // register file
   logic [DW-1:0] bus_ctrl1_ff,   bus_ctrl1_in;
   logic [HW-1:0] bus_ctrl2_ff,   bus_ctrl2_in;
   logic [DW-1:0] wait_ctrl1_ff,  wait_ctrl1_in;
   logic [DW-1:0] wait_ctrl2_ff,  wait_ctrl2_in;
   logic [DW-1:0] wait_ctrl3_ff,  wait_ctrl3_in;
   logic [DW-1:0] mem_ctrl_ff,    mem_ctrl_in;
   logic [HW-1:0] card_ctrl_ff,   card_ctrl_in;
   logic [HW-1:0] refresh_ff [4];
   logic [HW-1:0] refresh_in [4];
   logic [DW-1:0] pa_ctrl_ff,     pa_ctrl_in;
   logic [HW-1:0] pa_data_ff,     pa_data_in;
   logic [DW-1:0] pb_ctrl_ff,     pb_ctrl_in;
   logic [HW-1:0] pb_data_ff,     pb_data_in;
   logic [HW-1:0] gpio_irq_ff,    gpio_irq_in;
   logic [HW-1:0] latch_ff,       latch_in;
   logic [HW-1:0] out_mask_ff,    out_mask_in;
   logic [HW-1:0] pull_mask_ff,   pull_mask_in;
   logic [bcgrb_pkg::CableWidth-1:0] cable_ff;

   // response register
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_rdata_ff,   rsp_rdata_in;
   logic          rsp_error_ff,   rsp_error_in;

   logic          do_write;
   logic [HW-1:0] wdata16;
   logic [1:0]    refresh_idx;
   logic [DW-1:0] ctrl_decoded;
   logic [HW-1:0] ctrl_outs;
   logic [HW-1:0] ctrl_pulls;
   logic [1:0]    sense;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_mode_ff   <= bcgrb_pkg::mode_type'(req_mode);
      req_offset_ff <= bcgrb_pkg::reg_offset_type'(req_reg_offset);
      req_wdata_ff  <= req_write_data;
   end

   assign do_write    = req_valid_ff && (req_mode_ff == bcgrb_pkg::MODE_WRITE);
   assign wdata16     = req_wdata_ff[HW-1:0];
   assign refresh_idx = req_offset_ff[1:0] - bcgrb_pkg::RefreshBase;

   // per-pin decode: bit 2i selects output, bit 2i+1 clear pulls an input up
   always_comb begin
      ctrl_decoded = req_wdata_ff;
      ctrl_outs    = '0;
      ctrl_pulls   = '0;
      for (int i = 0; i < PORT_PINS; i++) begin
         if (req_wdata_ff[2*i]) begin
            ctrl_outs[i]          = 1'b1;
            ctrl_decoded[2*i + 1] = 1'b1;
         end else if (!req_wdata_ff[2*i + 1]) begin
            ctrl_pulls[i] = 1'b1;
         end
      end
   end

   always_comb begin
      sense = 2'b00;
      if (pa_ctrl_ff[3:0] == bcgrb_pkg::SenseCtrlOut) begin
         sense = bcgrb_pkg::SenseAll;
      end else if (pa_ctrl_ff[3:0] == bcgrb_pkg::SenseCtrlMixed) begin
         sense = (pa_data_ff[3:0] == bcgrb_pkg::SenseDataLow) ? 2'b00 : bcgrb_pkg::SenseAll;
      end else if (pa_ctrl_ff[3:0] == bcgrb_pkg::SenseCtrlIn &&
                   pa_data_ff[3:0] == bcgrb_pkg::SenseDataLow) begin
         sense = bcgrb_pkg::SenseAll;
      end
   end

   always_comb begin
      bus_ctrl1_in  = bus_ctrl1_ff;
      bus_ctrl2_in  = bus_ctrl2_ff;
      wait_ctrl1_in = wait_ctrl1_ff;
      wait_ctrl2_in = wait_ctrl2_ff;
      wait_ctrl3_in = wait_ctrl3_ff;
      mem_ctrl_in   = mem_ctrl_ff;
      card_ctrl_in  = card_ctrl_ff;
      refresh_in    = refresh_ff;
      pa_ctrl_in    = pa_ctrl_ff;
      pa_data_in    = pa_data_ff;
      pb_ctrl_in    = pb_ctrl_ff;
      pb_data_in    = pb_data_ff;
      gpio_irq_in   = gpio_irq_ff;
      latch_in      = latch_ff;
      out_mask_in   = out_mask_ff;
      pull_mask_in  = pull_mask_ff;
      rsp_rdata_in  = '0;
      rsp_error_in  = 1'b0;

      case (req_offset_ff)
         bcgrb_pkg::OFF_BUS_CTRL1: begin
            if (do_write) bus_ctrl1_in = req_wdata_ff;
            else rsp_rdata_in = bus_ctrl1_ff;
         end
         bcgrb_pkg::OFF_BUS_CTRL2: begin
            if (do_write) bus_ctrl2_in = wdata16;
            else rsp_rdata_in = {{(DW-HW){1'b0}}, bus_ctrl2_ff};
         end
         bcgrb_pkg::OFF_WAIT_CTRL1: begin
            if (do_write) wait_ctrl1_in = req_wdata_ff;
            else rsp_rdata_in = wait_ctrl1_ff;
         end
         bcgrb_pkg::OFF_WAIT_CTRL2: begin
            if (do_write) wait_ctrl2_in = req_wdata_ff;
            else rsp_rdata_in = wait_ctrl2_ff;
         end
         bcgrb_pkg::OFF_WAIT_CTRL3: begin
            if (do_write) wait_ctrl3_in = req_wdata_ff;
            else rsp_rdata_in = wait_ctrl3_ff;
         end
         bcgrb_pkg::OFF_MEM_CTRL: begin
            if (do_write) mem_ctrl_in = req_wdata_ff;
            else rsp_rdata_in = mem_ctrl_ff;
         end
         bcgrb_pkg::OFF_CARD_CTRL: begin
            if (do_write) card_ctrl_in = wdata16;
            else rsp_rdata_in = {{(DW-HW){1'b0}}, card_ctrl_ff};
         end
         bcgrb_pkg::OFF_REFRESH0, bcgrb_pkg::OFF_REFRESH1,
         bcgrb_pkg::OFF_REFRESH2, bcgrb_pkg::OFF_REFRESH3: begin
            if (do_write) refresh_in[refresh_idx] = wdata16;
            else rsp_rdata_in = {{(DW-HW){1'b0}}, refresh_ff[refresh_idx]};
         end
         bcgrb_pkg::OFF_PORT_A_CTRL: begin
            if (do_write) begin
               pa_ctrl_in   = ctrl_decoded;
               out_mask_in  = ctrl_outs;
               pull_mask_in = ctrl_pulls;
               latch_in     = (latch_ff & ~ctrl_outs) | (pa_data_ff & ctrl_outs);
            end else begin
               rsp_rdata_in = pa_ctrl_ff;
            end
         end
         bcgrb_pkg::OFF_PORT_A_DATA: begin
            if (do_write) begin
               pa_data_in = wdata16;
               latch_in   = (latch_ff & ~out_mask_ff) | (wdata16 & out_mask_ff);
            end else begin
               rsp_rdata_in = {{(DW-10){1'b0}}, cable_ff, 6'b000000, sense};
            end
         end
         bcgrb_pkg::OFF_PORT_B_CTRL: begin
            if (do_write) pb_ctrl_in = req_wdata_ff;
            else rsp_rdata_in = pb_ctrl_ff;
         end
         bcgrb_pkg::OFF_PORT_B_DATA: begin
            if (do_write) pb_data_in = wdata16;
            else rsp_error_in = 1'b1;
         end
         bcgrb_pkg::OFF_GPIO_IRQ: begin
            if (do_write) gpio_irq_in = wdata16;
            else rsp_rdata_in = {{(DW-HW){1'b0}}, gpio_irq_ff};
         end
         default: begin
            rsp_error_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ctrl1_ff  <= '0;
         bus_ctrl2_ff  <= bcgrb_pkg::BusCtrl2Reset;
         wait_ctrl1_ff <= bcgrb_pkg::WaitCtrl1Reset;
         wait_ctrl2_ff <= bcgrb_pkg::WaitCtrl2Reset;
         wait_ctrl3_ff <= bcgrb_pkg::WaitCtrl3Reset;
         mem_ctrl_ff   <= '0;
         card_ctrl_ff  <= '0;
         for (int j = 0; j < 4; j++) refresh_ff[j] <= '0;
         pa_ctrl_ff    <= '0;
         pa_data_ff    <= '0;
         pb_ctrl_ff    <= '0;
         pb_data_ff    <= '0;
         gpio_irq_ff   <= '0;
         latch_ff      <= '0;
         out_mask_ff   <= '0;
         pull_mask_ff  <= '0;
         cable_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bus_ctrl1_ff  <= bus_ctrl1_in;
         bus_ctrl2_ff  <= bus_ctrl2_in;
         wait_ctrl1_ff <= wait_ctrl1_in;
         wait_ctrl2_ff <= wait_ctrl2_in;
         wait_ctrl3_ff <= wait_ctrl3_in;
         mem_ctrl_ff   <= mem_ctrl_in;
         card_ctrl_ff  <= card_ctrl_in;
         refresh_ff    <= refresh_in;
         pa_ctrl_ff    <= pa_ctrl_in;
         pa_data_ff    <= pa_data_in;
         pb_ctrl_ff    <= pb_ctrl_in;
         pb_data_ff    <= pb_data_in;
         gpio_irq_ff   <= gpio_irq_in;
         latch_ff      <= latch_in;
         out_mask_ff   <= out_mask_in;
         pull_mask_ff  <= pull_mask_in;
         if (csr_write_enable) cable_ff <= csr_write_data;
         rsp_valid_ff  <= req_valid_ff;
      end
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_error_ff <= rsp_error_in;
   end

   // pin state registers already hold the post-access values during the beat
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = rsp_rdata_ff;
   assign rsp_access_error       = rsp_error_ff;
   assign rsp_port_a_drive       = latch_ff;
   assign rsp_port_a_output_mask = out_mask_ff;
   assign rsp_port_a_pullup_mask = pull_mask_ff;

   a_two_cycle_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   a_no_spurious_response: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> !rsp_valid)
      else $error("response without a request");

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      (rsp_port_a_output_mask & rsp_port_a_pullup_mask) == '0)
      else $error("pin both output and pulled up");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_error) |-> (rsp_read_data == '0))
      else $error("error response carries data");

endmodule

// ----- tb/tb_bus_controller_gpio_register_block.sv -----
`timescale 1ns / 100ps

module tb_bus_controller_gpio_register_block;

   localparam int unsigned WatchdogLimit = 1000;
   localparam int unsigned PhaseBeats    = 240;

   typedef struct packed {
      logic [bcgrb_pkg::DataWidth-1:0] read_data;
      logic                            access_error;
      logic [bcgrb_pkg::HalfWidth-1:0] drive;
      logic [bcgrb_pkg::HalfWidth-1:0] out_mask;
      logic [bcgrb_pkg::HalfWidth-1:0] pull_mask;
   } bus_reply_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_mode;
   logic [bcgrb_pkg::OffsetWidth-1:0] req_reg_offset;
   logic [bcgrb_pkg::DataWidth-1:0]   req_write_data;
   logic                              rsp_valid;
   logic [bcgrb_pkg::DataWidth-1:0]   rsp_read_data;
   logic                              rsp_access_error;
   logic [bcgrb_pkg::HalfWidth-1:0]   rsp_port_a_drive;
   logic [bcgrb_pkg::HalfWidth-1:0]   rsp_port_a_output_mask;
   logic [bcgrb_pkg::HalfWidth-1:0]   rsp_port_a_pullup_mask;
   logic                              csr_write_enable;
   logic [bcgrb_pkg::CableWidth-1:0]  csr_write_data;

   bus_controller_gpio_register_block u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_mode               (req_mode),
      .req_reg_offset         (req_reg_offset),
      .req_write_data         (req_write_data),
      .rsp_valid              (rsp_valid),
      .rsp_read_data          (rsp_read_data),
      .rsp_access_error       (rsp_access_error),
      .rsp_port_a_drive       (rsp_port_a_drive),
      .rsp_port_a_output_mask (rsp_port_a_output_mask),
      .rsp_port_a_pullup_mask (rsp_port_a_pullup_mask),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register file mirror
   logic [bcgrb_pkg::DataWidth-1:0]  bus_ctrl1, wait_ctrl1, wait_ctrl2, wait_ctrl3, mem_ctrl;
   logic [bcgrb_pkg::DataWidth-1:0]  pa_ctrl, pb_ctrl;
   logic [bcgrb_pkg::HalfWidth-1:0]  bus_ctrl2, card_ctrl, pa_data, pb_data, irq_ctrl;
   logic [bcgrb_pkg::HalfWidth-1:0]  refresh_mirror [4];
   logic [bcgrb_pkg::HalfWidth-1:0]  pin_latch, pin_out_mask, pin_pull_mask;
   logic [bcgrb_pkg::CableWidth-1:0] cable_code;

   bus_reply_type pending_bus_replies [$];
   int unsigned   mismatches, stall_cycles;
   int unsigned   read_beats, write_beats, error_replies, sense_hits;
   bit            cables_seen [4];

   function automatic void reset_register_mirror();
      bus_ctrl1     = '0;
      bus_ctrl2     = bcgrb_pkg::BusCtrl2Reset;
      wait_ctrl1    = bcgrb_pkg::WaitCtrl1Reset;
      wait_ctrl2    = bcgrb_pkg::WaitCtrl2Reset;
      wait_ctrl3    = bcgrb_pkg::WaitCtrl3Reset;
      mem_ctrl      = '0;
      card_ctrl     = '0;
      for (int i = 0; i < 4; i++) refresh_mirror[i] = '0;
      pa_ctrl       = '0;
      pa_data       = '0;
      pb_ctrl       = '0;
      pb_data       = '0;
      irq_ctrl      = '0;
      pin_latch     = '0;
      pin_out_mask  = '0;
      pin_pull_mask = '0;
      cable_code    = '0;
   endfunction

   function automatic void reload_pin_latch();
      pin_latch = (pin_latch & ~pin_out_mask) | (pa_data & pin_out_mask);
   endfunction

   // field 2i of pin i: bit 0 = output, bit 1 clear on an input = pulled up
   function automatic void decode_port_a_ctrl(logic [bcgrb_pkg::DataWidth-1:0] value);
      logic [bcgrb_pkg::HalfWidth-1:0] outs;
      logic [bcgrb_pkg::HalfWidth-1:0] pulls;
      outs  = '0;
      pulls = '0;
      for (int i = 0; i < bcgrb_pkg::PortPinsDefault && i < bcgrb_pkg::HalfWidth; i++) begin
         if (value[2*i]) begin
            outs[i]      = 1'b1;
            value[2*i+1] = 1'b1;
         end else if (!value[2*i+1]) begin
            pulls[i] = 1'b1;
         end
      end
      pa_ctrl       = value;
      pin_out_mask  = outs;
      pin_pull_mask = pulls;
      reload_pin_latch();
   endfunction

   function automatic logic [bcgrb_pkg::DataWidth-1:0] port_a_cable_sense();
      logic [3:0] c;
      logic [3:0] d;
      logic [1:0] s;
      c = pa_ctrl[3:0];
      d = pa_data[3:0];
      s = 2'b00;
      if (c == bcgrb_pkg::SenseCtrlOut)
         s = bcgrb_pkg::SenseAll;
      else if (c == bcgrb_pkg::SenseCtrlMixed)
         s = (d == bcgrb_pkg::SenseDataLow) ? 2'b00 : bcgrb_pkg::SenseAll;
      else if (c == bcgrb_pkg::SenseCtrlIn && d == bcgrb_pkg::SenseDataLow)
         s = bcgrb_pkg::SenseAll;
      return {22'd0, cable_code, 6'd0, s};
   endfunction

   function automatic bus_reply_type predict_access(bcgrb_pkg::mode_type m,
                                                    logic [bcgrb_pkg::OffsetWidth-1:0] off,
                                                    logic [bcgrb_pkg::DataWidth-1:0] wd);
      bus_reply_type r;
      logic          wr;
      logic [1:0]    ri;
      r  = '0;
      wr = (m == bcgrb_pkg::MODE_WRITE);
      ri = off[1:0] - bcgrb_pkg::RefreshBase;
      case (off)
         bcgrb_pkg::OFF_BUS_CTRL1:
            if (wr) bus_ctrl1 = wd;  else r.read_data = bus_ctrl1;
         bcgrb_pkg::OFF_BUS_CTRL2:
            if (wr) bus_ctrl2 = wd[15:0]; else r.read_data = {16'd0, bus_ctrl2};
         bcgrb_pkg::OFF_WAIT_CTRL1:
            if (wr) wait_ctrl1 = wd; else r.read_data = wait_ctrl1;
         bcgrb_pkg::OFF_WAIT_CTRL2:
            if (wr) wait_ctrl2 = wd; else r.read_data = wait_ctrl2;
         bcgrb_pkg::OFF_WAIT_CTRL3:
            if (wr) wait_ctrl3 = wd; else r.read_data = wait_ctrl3;
         bcgrb_pkg::OFF_MEM_CTRL:
            if (wr) mem_ctrl = wd;   else r.read_data = mem_ctrl;
         bcgrb_pkg::OFF_CARD_CTRL:
            if (wr) card_ctrl = wd[15:0]; else r.read_data = {16'd0, card_ctrl};
         bcgrb_pkg::OFF_REFRESH0, bcgrb_pkg::OFF_REFRESH1,
         bcgrb_pkg::OFF_REFRESH2, bcgrb_pkg::OFF_REFRESH3: begin
            if (wr) refresh_mirror[ri] = wd[15:0];
            else r.read_data = {16'd0, refresh_mirror[ri]};
         end
         bcgrb_pkg::OFF_PORT_A_CTRL:
            if (wr) decode_port_a_ctrl(wd); else r.read_data = pa_ctrl;
         bcgrb_pkg::OFF_PORT_A_DATA: begin
            if (wr) begin
               pa_data = wd[15:0];
               reload_pin_latch();
            end else begin
               r.read_data = port_a_cable_sense();
            end
         end
         bcgrb_pkg::OFF_PORT_B_CTRL:
            if (wr) pb_ctrl = wd; else r.read_data = pb_ctrl;
         bcgrb_pkg::OFF_PORT_B_DATA:
            if (wr) pb_data = wd[15:0]; else r.access_error = 1'b1;
         bcgrb_pkg::OFF_GPIO_IRQ:
            if (wr) irq_ctrl = wd[15:0]; else r.read_data = {16'd0, irq_ctrl};
         default: r.access_error = 1'b1;
      endcase
      r.drive     = pin_latch;
      r.out_mask  = pin_out_mask;
      r.pull_mask = pin_pull_mask;
      return r;
   endfunction

   function automatic void check_field(string name, logic [bcgrb_pkg::DataWidth-1:0] want,
                                       logic [bcgrb_pkg::DataWidth-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   // scoreboard, prediction on accepted beats, watchdog
   always @(posedge clock) begin
      bus_reply_type want;
      bit            moved;
      if (reset) begin
         reset_register_mirror();
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            if (pending_bus_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t reply with nothing outstanding", $realtime);
            end else begin
               want = pending_bus_replies.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("access_error", 32'(want.access_error), 32'(rsp_access_error));
               check_field("port_a_drive", 32'(want.drive), 32'(rsp_port_a_drive));
               check_field("output_mask", 32'(want.out_mask), 32'(rsp_port_a_output_mask));
               check_field("pullup_mask", 32'(want.pull_mask), 32'(rsp_port_a_pullup_mask));
               if (rsp_access_error === 1'b1) error_replies++;
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            want  = predict_access(bcgrb_pkg::mode_type'(req_mode), req_reg_offset,
                                   req_write_data);
            pending_bus_replies.push_back(want);
            if (req_mode == bcgrb_pkg::MODE_WRITE) write_beats++;
            else read_beats++;
            if (req_mode == bcgrb_pkg::MODE_READ &&
                req_reg_offset == bcgrb_pkg::OFF_PORT_A_DATA &&
                want.read_data[1:0] == bcgrb_pkg::SenseAll)
               sense_hits++;
         end
         if (csr_write_enable) begin
            moved      = 1'b1;
            cable_code = csr_write_data;
            cables_seen[csr_write_data] = 1'b1;
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("%0t watchdog: no progress for %0d cycles", $realtime, stall_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_access(bcgrb_pkg::mode_type m,
                              logic [bcgrb_pkg::OffsetWidth-1:0] off,
                              logic [bcgrb_pkg::DataWidth-1:0] wd);
      @(negedge clock);
      start          <= 1'b1;
      req_mode       <= m;
      req_reg_offset <= off;
      req_write_data <= wd;
      do @(posedge clock); while (busy);
   endtask

   // start held low; request fields carry junk meanwhile
   task automatic idle_burst(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start          <= 1'b0;
         req_mode       <= 1'($urandom);
         req_reg_offset <= 6'($urandom);
         req_write_data <= $urandom;
      end
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      start <= 1'b0;
      while (pending_bus_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_cable_code(logic [bcgrb_pkg::CableWidth-1:0] code);
      wait_for_replies();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_BUS_CTRL2, '0);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_WAIT_CTRL2, '1);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_WAIT_CTRL3, '0);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_DATA, '0);
   endtask

   task automatic test_write_widths();
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_BUS_CTRL1, 32'hFFFF_FFFF);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_BUS_CTRL1, '0);
      // 16-bit register drops the upper half
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_BUS_CTRL2, 32'hFFFF_FFFF);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_BUS_CTRL2, '1);
   endtask

   task automatic test_cable_sense();
      set_cable_code(2'd3);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_CTRL, 32'h0000_0008);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_DATA, '0);
      // 0x9 stores as 0xB: output pin gets its no-pull-up bit forced
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_CTRL, 32'h0000_0009);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_DATA, 32'hFFFF_0002);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_DATA, '0);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_DATA, 32'h0000_FFFF);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_DATA, '0);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_CTRL, 32'h0000_0004);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_A_DATA, 32'h0000_0002);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_DATA, '0);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_A_CTRL, '0);
   endtask

   task automatic test_port_b_and_unmapped();
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_B_DATA, 32'hFFFF_FFFF);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_B_DATA, '0);
      send_access(bcgrb_pkg::MODE_WRITE, bcgrb_pkg::OFF_PORT_B_CTRL, 32'hA5A5_5A5A);
      send_access(bcgrb_pkg::MODE_READ, bcgrb_pkg::OFF_PORT_B_CTRL, '0);
      send_access(bcgrb_pkg::MODE_READ, 6'd13, '0);
      send_access(bcgrb_pkg::MODE_WRITE, 6'd63, 32'hFFFF_FFFF);
   endtask

   function automatic logic [bcgrb_pkg::OffsetWidth-1:0] pick_offset();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(0, 1) ? bcgrb_pkg::OFF_PORT_A_CTRL
                                              : bcgrb_pkg::OFF_PORT_A_DATA;
         3:       return $urandom_range(0, 1) ? bcgrb_pkg::OFF_PORT_B_CTRL
                                              : bcgrb_pkg::OFF_PORT_B_DATA;
         4:       return $urandom_range(0, 3) == 0 ? 6'($urandom_range(13, 15))
                                                   : 6'($urandom_range(19, 63));
         default: return $urandom_range(0, 5) == 0 ? 6'($urandom_range(16, 18))
                                                   : 6'($urandom_range(0, 12));
      endcase
   endfunction

   function automatic logic [bcgrb_pkg::DataWidth-1:0] pick_write_data();
      logic [3:0] nibbles [8] = '{4'h8, 4'hB, 4'hC, 4'h9, 4'h4, 4'h2, 4'h0, 4'hF};
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return {28'($urandom), nibbles[$urandom_range(0, 7)]};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_traffic(int unsigned beats, bit with_gaps);
      for (int unsigned i = 0; i < beats; i++) begin
         if (with_gaps && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 5));
         // hold off once per phase until the pipe is empty
         if (i == beats / 2) wait_for_replies();
         send_access(bcgrb_pkg::mode_type'($urandom_range(0, 1)), pick_offset(),
                     pick_write_data());
      end
   endtask

   task automatic test_cable_phases();
      logic [bcgrb_pkg::CableWidth-1:0] codes [5] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0};
      codes[4] = 2'($urandom);
      for (int p = 0; p < 5; p++) begin
         set_cable_code(codes[p]);
         test_random_traffic(PhaseBeats, p != 4);
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = bcgrb_pkg::MODE_READ;
      req_reg_offset   = '0;
      req_write_data   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      mismatches       = 0;
      read_beats       = 0;
      write_beats      = 0;
      error_replies    = 0;
      sense_hits       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_write_widths();
      test_cable_sense();
      test_port_b_and_unmapped();
      test_cable_phases();

      wait_for_replies();
      repeat (4) @(posedge clock);
      if (pending_bus_replies.size() != 0) begin
         mismatches++;
         $display("%0d replies never arrived", pending_bus_replies.size());
      end
      $display("Covered %0d reads and %0d writes, %0d error replies, %0d cable sense hits",
               read_beats, write_beats, error_replies, sense_hits);
      $display("Cable codes exercised: %0b%0b%0b%0b (3..0), mismatches: %0d",
               cables_seen[3], cables_seen[2], cables_seen[1], cables_seen[0], mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bcgrb_pkg.sv
hw/rtl/bus_controller_gpio_register_block.sv
tb/tb_bus_controller_gpio_register_block.sv
